@@ hdl/rtog_pkg.sv @@
// shared types and constants for the region table
package rtog_pkg;

    localparam int MAX_REGIONS = 16;
    localparam int IDX_W = $clog2(MAX_REGIONS);
    localparam int CNT_W = $clog2(MAX_REGIONS + 1);

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_FIND   = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_GAP    = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_CONFLICT = 3'd1,
        ST_BADARG   = 3'd2,
        ST_FULL     = 3'd3,
        ST_MISSING  = 3'd4
    } t_status;

    typedef struct packed {
        t_mode       mode;
        logic [31:0] region_start;
        logic [31:0] region_length;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [31:0] result_address;
        logic [31:0] result_end;
    } t_rsp;

    typedef struct packed {
        logic [31:0] start_addr;
        logic [31:0] end_addr;
    } t_entry;

endpackage

@@ hdl/rtog_ram.sv @@
// generic single write port, single read port ram with registered read
module rtog_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/region_table_overlap_and_gap_top.sv @@
// region table top: sequencer over the entry ram for insert, find, remove and gap search
//
// channel   direction  signals                 transfer
// request   in         start, busy, i_req      start high while busy low
// result    out        o_strobe, o_rsp         o_strobe high for one cycle
//
// one operation at a time; busy is high from the cycle after a request transfer
// until the cycle its result is strobed. find scans and evaluates; insert scans,
// evaluates, makes a shift-up pass and writes; remove scans, evaluates and makes
// a shift-down pass; gap search scans down from the top entry. argument rejects,
// a full or empty table and gap search with fewer than two regions answer without
// a scan, with busy kept low. the single read port of the entry ram paces each
// pass. reset empties the table at once (no clearing pass); the result side cannot stall.
module region_table_overlap_and_gap_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  rtog_pkg::t_req i_req,
    output logic           o_strobe,
    output rtog_pkg::t_rsp o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_SHIFT,
        S_WRITE,
        S_GAP
    } t_state;

    t_state                         r_state;
    rtog_pkg::t_req                 r_req;
    logic [31:0]                    r_end;
    logic [rtog_pkg::CNT_W-1:0]     r_count;
    logic [rtog_pkg::CNT_W-1:0]     r_idx;
    logic [rtog_pkg::CNT_W-1:0]     r_left;
    logic [rtog_pkg::CNT_W-1:0]     r_pos;
    logic                           r_pv;
    logic [rtog_pkg::IDX_W-1:0]     r_pidx;
    logic                           r_hit;
    logic [rtog_pkg::IDX_W-1:0]     r_k;
    rtog_pkg::t_entry               r_found;
    logic [31:0]                    r_prev_start;
    logic                           r_have_prev;
    logic                           r_strobe;
    rtog_pkg::t_rsp                 r_rsp;

    logic                           ram_we;
    logic [rtog_pkg::IDX_W-1:0]     ram_waddr;
    rtog_pkg::t_entry               ram_wdata;
    rtog_pkg::t_entry               ram_rdata;
    logic [$bits(rtog_pkg::t_entry)-1:0] ram_rbits;

    logic                           accept;
    logic [31:0]                    acc_end;
    logic                           overlap;
    logic                           start_le;
    logic                           start_eq;
    logic [31:0]                    room;
    logic                           is_insert;

    rtog_ram #(
        .DEPTH (rtog_pkg::MAX_REGIONS),
        .WIDTH ($bits(rtog_pkg::t_entry))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[rtog_pkg::IDX_W-1:0]),
        .o_rdata (ram_rbits)
    );

    assign ram_rdata = rtog_pkg::t_entry'(ram_rbits);
    assign accept    = start && (r_state == S_IDLE);
    assign acc_end   = i_req.region_start + i_req.region_length;
    assign is_insert = (r_req.mode == rtog_pkg::MODE_INSERT);

    // overlap and ordering checks against the entry just read
    always_comb begin
        overlap = ((r_req.region_start > ram_rdata.start_addr) &&
                   (r_req.region_start < ram_rdata.end_addr)) ||
                  ((r_end > ram_rdata.start_addr) && (r_end < ram_rdata.end_addr)) ||
                  ((r_req.region_start < ram_rdata.start_addr) &&
                   (r_end > ram_rdata.end_addr));
        start_le = (ram_rdata.start_addr <= r_req.region_start);
        start_eq = (ram_rdata.start_addr == r_req.region_start);
        room     = r_prev_start - ram_rdata.end_addr;
    end

    // ram write side: shift moves and the final insert write
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pos[rtog_pkg::IDX_W-1:0];
        ram_wdata = '{start_addr: r_req.region_start, end_addr: r_end};
        case (r_state)
            S_SHIFT: begin
                ram_we    = r_pv;
                ram_waddr = is_insert ? (r_pidx + 1'b1) : (r_pidx - 1'b1);
                ram_wdata = ram_rdata;
            end
            S_WRITE: begin
                ram_we = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_pv     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_pv <= 1'b0;
                    if (accept) begin
                        r_req       <= i_req;
                        r_end       <= acc_end;
                        r_idx       <= '0;
                        r_hit       <= 1'b0;
                        r_pos       <= '0;
                        r_have_prev <= 1'b0;
                        r_rsp       <= '{status: rtog_pkg::ST_OK,
                                         result_address: 32'd0, result_end: 32'd0};
                        case (i_req.mode)
                            rtog_pkg::MODE_INSERT: begin
                                if ((i_req.region_start == 32'd0) ||
                                    (i_req.region_length == 32'd0) ||
                                    (i_req.region_start >= acc_end)) begin
                                    r_rsp.status <= rtog_pkg::ST_BADARG;
                                    r_strobe     <= 1'b1;
                                end else if (r_count >=
                                             rtog_pkg::CNT_W'(rtog_pkg::MAX_REGIONS)) begin
                                    r_rsp.status <= rtog_pkg::ST_FULL;
                                    r_strobe     <= 1'b1;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            rtog_pkg::MODE_FIND, rtog_pkg::MODE_REMOVE: begin
                                if (r_count == '0) begin
                                    r_rsp.status <= rtog_pkg::ST_MISSING;
                                    r_strobe     <= 1'b1;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            rtog_pkg::MODE_GAP: begin
                                if (i_req.region_length == 32'd0) begin
                                    r_rsp.status <= rtog_pkg::ST_BADARG;
                                    r_strobe     <= 1'b1;
                                end else if (r_count < rtog_pkg::CNT_W'(2)) begin
                                    r_rsp.status <= rtog_pkg::ST_CONFLICT;
                                    r_strobe     <= 1'b1;
                                end else begin
                                    r_idx   <= r_count - 1'b1;
                                    r_left  <= r_count;
                                    r_state <= S_GAP;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_idx != r_count) begin
                        r_pv   <= 1'b1;
                        r_pidx <= r_idx[rtog_pkg::IDX_W-1:0];
                        r_idx  <= r_idx + 1'b1;
                    end else begin
                        r_pv    <= 1'b0;
                        r_state <= S_EVAL;
                    end
                    if (r_pv) begin
                        if (is_insert) begin
                            if (overlap) begin
                                r_hit <= 1'b1;
                            end
                            if (start_le) begin
                                r_pos <= r_pos + 1'b1;
                            end
                        end else if (start_eq) begin
                            r_hit   <= 1'b1;
                            r_k     <= r_pidx;
                            r_found <= ram_rdata;
                        end
                    end
                end
                S_EVAL: begin
                    r_pv <= 1'b0;
                    case (r_req.mode)
                        rtog_pkg::MODE_INSERT: begin
                            if (r_hit) begin
                                r_rsp.status <= rtog_pkg::ST_CONFLICT;
                                r_strobe     <= 1'b1;
                                r_state      <= S_IDLE;
                            end else begin
                                r_idx   <= r_count - 1'b1;
                                r_left  <= r_count - r_pos;
                                r_state <= S_SHIFT;
                            end
                        end
                        rtog_pkg::MODE_FIND: begin
                            if (r_hit) begin
                                r_rsp <= '{status: rtog_pkg::ST_OK,
                                           result_address: r_found.start_addr,
                                           result_end: r_found.end_addr};
                            end else begin
                                r_rsp.status <= rtog_pkg::ST_MISSING;
                            end
                            r_strobe <= 1'b1;
                            r_state  <= S_IDLE;
                        end
                        rtog_pkg::MODE_REMOVE: begin
                            if (r_hit) begin
                                r_idx   <= rtog_pkg::CNT_W'(r_k) + 1'b1;
                                r_left  <= r_count - rtog_pkg::CNT_W'(r_k) - 1'b1;
                                r_state <= S_SHIFT;
                            end else begin
                                r_rsp.status <= rtog_pkg::ST_MISSING;
                                r_strobe     <= 1'b1;
                                r_state      <= S_IDLE;
                            end
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_SHIFT: begin
                    if (r_left != '0) begin
                        r_pv   <= 1'b1;
                        r_pidx <= r_idx[rtog_pkg::IDX_W-1:0];
                        r_idx  <= is_insert ? (r_idx - 1'b1) : (r_idx + 1'b1);
                        r_left <= r_left - 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                        if (!r_pv) begin
                            if (is_insert) begin
                                r_state <= S_WRITE;
                            end else begin
                                r_count  <= r_count - 1'b1;
                                r_rsp    <= '{status: rtog_pkg::ST_OK,
                                              result_address: r_found.start_addr,
                                              result_end: r_found.end_addr};
                                r_strobe <= 1'b1;
                                r_state  <= S_IDLE;
                            end
                        end
                    end
                end
                S_WRITE: begin
                    r_count  <= r_count + 1'b1;
                    r_rsp    <= '{status: rtog_pkg::ST_OK,
                                  result_address: r_req.region_start, result_end: r_end};
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_GAP: begin
                    if (r_left != '0) begin
                        r_pv   <= 1'b1;
                        r_idx  <= r_idx - 1'b1;
                        r_left <= r_left - 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv) begin
                        r_prev_start <= ram_rdata.start_addr;
                        r_have_prev  <= 1'b1;
                    end
                    if (r_pv && r_have_prev && (room >= r_req.region_length)) begin
                        r_rsp    <= '{status: rtog_pkg::ST_OK,
                                      result_address: r_prev_start - r_req.region_length,
                                      result_end: 32'd0};
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end else if ((r_left == '0) && !r_pv) begin
                        r_rsp.status <= rtog_pkg::ST_CONFLICT;
                        r_strobe     <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule
